// File: hw/rtl/bra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg: shared types and codes for the bitmap region allocator
// Request kinds, sequencer states and stream field widths.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int unsigned REQ_TYPE_W  = 2;
    localparam int unsigned START_W     = 10;
    localparam int unsigned LEN_W       = 11;
    localparam int unsigned LIMIT_W     = 11;
    localparam int unsigned FREE_IDX_W  = 10;
    localparam int unsigned S_TDATA_W   = 40;
    localparam int unsigned M_TDATA_W   = 16;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_MARK    = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_NONE    = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } seq_state_t;

endpackage

// File: hw/rtl/bitmap_region_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_region_allocator_top: first-fit bitmap allocator
// One request at a time: the next request is accepted only after the sweep
// ends and its result is loaded, which waits while a previous result is still
// held on the output by m_tready low.
// Every request sweeps all map words through one read-modify-write mask unit.
// Reset: aresetn low clears control; afterwards a clearing pass over all map
// words zeroes the map memory while s_tready stays low.
// ----------------------------------------------------------------------------
module bitmap_region_allocator_top #(
    parameter int unsigned MAP_BITS  = 1024,
    parameter int unsigned WORD_BITS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // req_type[1:0], start_index[11:2], run_length[22:12], search_limit[33:23]
    input  logic [bra_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found[0], free_index[10:1], range_error[11]
    output logic [bra_pkg::M_TDATA_W-1:0] m_tdata
);
    import bra_pkg::*;

    localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WAW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned PW0 = $clog2(MAP_BITS + WORD_BITS);
    localparam int unsigned PW  = (PW0 > 12) ? PW0 : 12;
    localparam int unsigned OW  = $clog2(WORD_BITS + 1);
    localparam int unsigned BW  = $clog2(WORD_BITS);
    localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};

    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

    seq_state_t           state_reg, state_next;
    logic [WAW-1:0]       addr_reg;
    logic [PW-1:0]        base_reg;
    req_kind_t            kind_reg;
    logic [PW-1:0]        lo_reg, hi_reg;
    logic                 err_reg;
    logic                 s2_valid_reg;
    logic [WAW-1:0]       s2_addr_reg;
    logic [PW-1:0]        s2_base_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 found_reg;
    logic [PW-1:0]        idx_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                 req_accept;
    logic                 last_word;
    logic                 out_load;
    req_kind_t            req_kind;
    logic [PW-1:0]        req_start, req_end_raw, req_end, req_lim;
    logic                 req_err;
    logic [OW-1:0]        lo_off, hi_off;
    logic [PW-1:0]        lo_diff, hi_diff;
    logic [WORD_BITS-1:0] run_mask, cand, low_one, wr_data;
    logic                 wr_en;
    logic [BW-1:0]        bit_pos;

    assign s_tready   = (state_reg == ST_IDLE);
    assign req_accept = s_tvalid && s_tready;
    assign last_word  = (addr_reg == WAW'(MAP_WORDS - 1));
    assign out_load   = (state_reg == ST_FINISH) && !s2_valid_reg
                        && (!m_tvalid_reg || m_tready);

    // decode request
    always_comb begin
        req_kind    = req_kind_t'(s_tdata[1:0]);
        req_start   = PW'(s_tdata[11:2]);
        req_end_raw = PW'(s_tdata[11:2]) + PW'(s_tdata[22:12]);
        req_end     = (req_end_raw > PW'(MAP_BITS)) ? PW'(MAP_BITS) : req_end_raw;
        req_lim     = (PW'(s_tdata[33:23]) > PW'(MAP_BITS)) ? PW'(MAP_BITS)
                                                              : PW'(s_tdata[33:23]);
        req_err     = ((req_kind == REQ_MARK) || (req_kind == REQ_RELEASE))
                      && (s_tdata[22:12] != '0) && (req_end_raw > PW'(MAP_BITS));
    end

    // mask unit: bits of this word inside [lo, hi)
    always_comb begin
        lo_diff = lo_reg - s2_base_reg;
        hi_diff = hi_reg - s2_base_reg;
        if (lo_reg <= s2_base_reg) begin
            lo_off = '0;
        end else if (lo_diff >= PW'(WORD_BITS)) begin
            lo_off = OW'(WORD_BITS);
        end else begin
            lo_off = lo_diff[OW-1:0];
        end
        if (hi_reg <= s2_base_reg) begin
            hi_off = '0;
        end else if (hi_diff >= PW'(WORD_BITS)) begin
            hi_off = OW'(WORD_BITS);
        end else begin
            hi_off = hi_diff[OW-1:0];
        end
        run_mask = (WORD_ONES << lo_off) & ~(WORD_ONES << hi_off);
        cand     = ~rd_data_reg & run_mask;
        low_one  = cand & (~cand + WORD_BITS'(1));
        bit_pos  = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            bit_pos = bit_pos | (low_one[j] ? BW'(j) : '0);
        end
        wr_en   = s2_valid_reg && ((kind_reg == REQ_MARK) || (kind_reg == REQ_RELEASE));
        wr_data = (kind_reg == REQ_MARK) ? (rd_data_reg | run_mask)
                                         : (rd_data_reg & ~run_mask);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (last_word) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (req_accept) state_next = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (last_word) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s2_valid_reg <= (state_reg == ST_SWEEP);
            if (((state_reg == ST_CLEAR) || (state_reg == ST_SWEEP)) && !last_word) begin
                addr_reg <= addr_reg + WAW'(1);
            end else if (state_reg != ST_SWEEP || last_word) begin
                addr_reg <= '0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // request and word datapath
    always_ff @(posedge aclk) begin
        if (req_accept) begin
            kind_reg  <= req_kind;
            err_reg   <= req_err;
            found_reg <= 1'b0;
            idx_reg   <= '0;
            base_reg  <= '0;
            if (req_kind == REQ_QUERY) begin
                lo_reg <= '0;
                hi_reg <= req_lim;
            end else begin
                lo_reg <= req_start;
                hi_reg <= req_end;
            end
        end else begin
            if (state_reg == ST_SWEEP) base_reg <= base_reg + PW'(WORD_BITS);
            if (s2_valid_reg && (kind_reg == REQ_QUERY) && !found_reg
                && (cand != '0)) begin
                found_reg <= 1'b1;
                idx_reg   <= s2_base_reg + PW'(bit_pos);
            end
        end
        s2_addr_reg <= addr_reg;
        s2_base_reg <= base_reg;
        if (out_load) begin
            m_tdata_reg <= {4'b0, err_reg, idx_reg[FREE_IDX_W-1:0], found_reg};
        end
    end

    // map memory
    always_ff @(posedge aclk) begin
        rd_data_reg <= map_mem[addr_reg];
        if (state_reg == ST_CLEAR) begin
            map_mem[addr_reg] <= '0;
        end else if (wr_en) begin
            map_mem[s2_addr_reg] <= wr_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("request accepted during map clearing");
    a_accept_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        req_accept |=> (state_reg == ST_SWEEP))
        else $error("accepted request did not start a sweep");
    a_s2_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> ((state_reg == ST_SWEEP) || (state_reg == ST_FINISH)))
        else $error("word stage active outside a sweep");
    a_found_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (found_reg && (state_reg != ST_IDLE)) |-> (kind_reg == REQ_QUERY))
        else $error("found flag set for a non-query request");
`endif

endmodule
